/* hw/rtl/assert_macros.svh */
// assertion macros included by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// implication whose property is checked in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

/* hw/rtl/dqip_pkg.sv */
// types and constants for the dotted quad address parser
`default_nettype none

package dqip_pkg;

    // parse phase inside one field
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SPACE  = 2'd1,
        PH_SIGN   = 2'd2,
        PH_DIGITS = 2'd3
    } phase_t;

    localparam logic [7:0]  CH_NUL   = 8'h00;
    localparam logic [7:0]  CH_DOT   = 8'h2E;
    localparam logic [7:0]  CH_PLUS  = 8'h2B;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_TAB   = 8'h09;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [8:0]  ACC_SAT  = 9'd256;
    localparam logic [8:0]  OCTET_MAX = 9'd255;
    localparam logic [1:0]  LAST_FIELD = 2'd3;
    localparam logic [31:0] ADDR_INVALID = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

/* hw/rtl/dotted_quad_ipv4_parser.sv */
// dotted quad address parser top level
//
// Input channel: one character per item on ch, qualified by in_valid and
// held off by in_stall. A zero byte ends the address text.
// Output channel: one item per zero byte, valid_res and address, qualified
// by out_valid and held off by out_stall. address packs field one in bits
// 7:0 up to field four in bits 31:24, and is all ones when valid_res is 0.
// A character goes into an input register, then the per-character update
// (whitespace/sign/digit decode, multiply by ten and saturate) runs between
// that register and the state and result registers, so a result is
// registered when its zero byte leaves the input register.
// Throughput: one character per cycle while in_stall is low, set by the single update stage.
// A stalled receiver holds the result; non-zero characters keep flowing,
// and only a zero byte waits in the input register until the result slot
// frees, which then stalls the input side.
// Reset: clears the field state, stored octets and both valid flags.
`default_nettype none

`include "assert_macros.svh"

module dotted_quad_ipv4_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  ch,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             valid_res,
    output logic [31:0]      address
);
    import dqip_pkg::*;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_ch_reg;

    // parse state
    phase_t     field_phase_reg, field_phase_next;
    logic [1:0] field_index_reg, field_index_next;
    logic       negative_reg, negative_next;
    logic [8:0] acc_reg, acc_next;
    logic [7:0] octet_reg [3];
    logic       failed_reg, failed_next;
    logic       close_field;

    // result register
    logic        out_valid_reg;
    logic        valid_res_reg, valid_res_next;
    logic [31:0] address_reg, address_next;

    logic out_free;
    logic s1_is_nul;
    logic s1_proc;
    logic is_space, is_digit, is_sign, is_dot;
    logic value_ok;
    logic [12:0] acc_mul;

    // handshake control
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_is_nul = (s1_ch_reg == CH_NUL);
    assign s1_proc   = s1_valid_reg && (!s1_is_nul || out_free);
    assign in_stall  = s1_valid_reg && !s1_proc;

    // character classes
    assign is_space = (s1_ch_reg == CH_SPACE) ||
                      (s1_ch_reg >= CH_TAB && s1_ch_reg <= CH_CR);
    assign is_digit = (s1_ch_reg >= CH_ZERO) && (s1_ch_reg <= CH_NINE);
    assign is_sign  = (s1_ch_reg == CH_PLUS) || (s1_ch_reg == CH_MINUS);
    assign is_dot   = (s1_ch_reg == CH_DOT);
    assign value_ok = (acc_reg <= OCTET_MAX) && !(negative_reg && acc_reg != 9'd0);

    // accumulate one digit: acc * 10 + digit
    assign acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {9'd0, s1_ch_reg[3:0]};

    // next parse state
    always_comb
    begin
        field_phase_next = field_phase_reg;
        field_index_next = field_index_reg;
        negative_next    = negative_reg;
        acc_next         = acc_reg;
        failed_next      = failed_reg;
        close_field      = 1'b0;
        if (s1_is_nul)
        begin
            field_phase_next = PH_START;
            field_index_next = 2'd0;
            negative_next    = 1'b0;
            acc_next         = 9'd0;
            failed_next      = 1'b0;
        end
        else if (!failed_reg)
        begin
            unique case (field_phase_reg)
                PH_START, PH_SPACE:
                begin
                    if (is_space)
                        field_phase_next = PH_SPACE;
                    else if (is_sign)
                    begin
                        negative_next    = (s1_ch_reg == CH_MINUS);
                        field_phase_next = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        acc_next = (acc_mul > {4'd0, ACC_SAT}) ? ACC_SAT : acc_mul[8:0];
                        field_phase_next = PH_DIGITS;
                    end
                    else if (is_dot && field_phase_reg == PH_START &&
                             field_index_reg != LAST_FIELD)
                        close_field = 1'b1;
                    else
                        failed_next = 1'b1;
                end
                PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        acc_next = (acc_mul > {4'd0, ACC_SAT}) ? ACC_SAT : acc_mul[8:0];
                        field_phase_next = PH_DIGITS;
                    end
                    else
                        failed_next = 1'b1;
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                        acc_next = (acc_mul > {4'd0, ACC_SAT}) ? ACC_SAT : acc_mul[8:0];
                    else if (is_dot && field_index_reg != LAST_FIELD && value_ok)
                        close_field = 1'b1;
                    else
                        failed_next = 1'b1;
                end
                default:
                    failed_next = 1'b1;
            endcase
            if (close_field)
            begin
                field_index_next = field_index_reg + 2'd1;
                field_phase_next = PH_START;
                negative_next    = 1'b0;
                acc_next         = 9'd0;
            end
        end
    end

    // result at the zero byte
    always_comb
    begin
        logic       ok;
        logic [7:0] last;
        ok   = !failed_reg && (field_index_reg == LAST_FIELD);
        last = 8'd0;
        if (ok)
        begin
            if (field_phase_reg == PH_DIGITS)
            begin
                ok   = value_ok;
                last = acc_reg[7:0];
            end
            else if (field_phase_reg != PH_START)
                ok = 1'b0;
        end
        valid_res_next = ok;
        address_next   = ok ? {last, octet_reg[2], octet_reg[1], octet_reg[0]}
                            : ADDR_INVALID;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_ch_reg <= ch;
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_phase_reg <= PH_START;
            field_index_reg <= 2'd0;
            negative_reg    <= 1'b0;
            acc_reg         <= 9'd0;
            failed_reg      <= 1'b0;
            for (int i = 0; i < 3; i++)
                octet_reg[i] <= 8'd0;
        end
        else if (s1_proc)
        begin
            field_phase_reg <= field_phase_next;
            field_index_reg <= field_index_next;
            negative_reg    <= negative_next;
            acc_reg         <= acc_next;
            failed_reg      <= failed_next;
            for (int i = 0; i < 3; i++)
            begin
                if (s1_is_nul)
                    octet_reg[i] <= 8'd0;
                else if (close_field && field_index_reg == 2'(i))
                    octet_reg[i] <= acc_reg[7:0];
            end
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_proc && s1_is_nul;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_proc && s1_is_nul)
        begin
            valid_res_reg <= valid_res_next;
            address_reg   <= address_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign address   = address_reg;

    // checks
    `ASSERT_CLK(a_invalid_all_ones, clk, rst_n,
        (out_valid_reg && !valid_res_reg) |-> (address_reg == ADDR_INVALID))
    `ASSERT_NEXT(a_nul_resets_state, clk, rst_n, (s1_proc && s1_is_nul),
        (field_index_reg == 2'd0 && !failed_reg && acc_reg == 9'd0))
    `ASSERT_CLK(a_stall_needs_item, clk, rst_n,
        in_stall |-> (s1_valid_reg && s1_is_nul && out_valid_reg))
    `ASSERT_CLK(a_acc_saturated, clk, rst_n, acc_reg <= ACC_SAT)

endmodule

`default_nettype wire
